>>> rtl/ppve_pkg.sv
// ----------------------------------------------------------------------------
// ppve_pkg
// Types and constants shared by the program-stream video extractor.
// ----------------------------------------------------------------------------
package ppve_pkg;

  // Length of the fixed PES header: start code, packet length, two flag
  // bytes and the header-data length byte.
  localparam int unsigned PES_HEADER_BYTES = 9;
  localparam logic [7:0]  HDR_LAST_IDX     = 8'(PES_HEADER_BYTES - 1);
  localparam logic [7:0]  HDR_FIRST_IDX    = 8'd4;
  localparam logic [7:0]  HDR_LEN_HI_IDX   = 8'd4;
  localparam logic [7:0]  HDR_LEN_LO_IDX   = 8'd5;

  // Flag bytes plus the header-data length byte, counted in packet_length.
  localparam logic [8:0]  PES_FIXED_OVERHEAD = 9'd3;

  localparam logic [1:0]  WINDOW_FULL    = 2'd3;
  localparam logic [23:0] START_PREFIX   = 24'h000001;

  localparam logic [7:0]  VIDEO_CODE_RST = 8'hE0;
  localparam logic [7:0]  AUDIO_CODE_RST = 8'hC0;

  // Configuration register indexes.
  localparam logic CFG_VIDEO_CODE = 1'b0;
  localparam logic CFG_AUDIO_CODE = 1'b1;

  // Depth of the result queue; it must hold the two results of one item.
  localparam int unsigned OUT_QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    PH_SCAN    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_SKIP    = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       buffer_done;
    logic       status;
  } out_word_t;

  // Results handed from the parser to the result queue in the same cycle.
  typedef struct packed {
    logic [1:0] count;
    out_word_t  first;
    out_word_t  second;
  } push_t;

endpackage

>>> rtl/ppve_core.sv
// ----------------------------------------------------------------------------
// ppve_core
// Byte-wide PES parser: start-code window, header, header-data skip and
// payload counting, with the stream-id registers.
// ----------------------------------------------------------------------------
module ppve_core import ppve_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       accept_i,
  input  in_word_t   in_data_i,
  output push_t      push_o
);

  logic [7:0]  video_code_q, audio_code_q;
  logic [23:0] look_q, look_d;
  logic [1:0]  look_cnt_q, look_cnt_d;
  phase_e      phase_q, phase_d;
  logic [7:0]  hidx_q, hidx_d;
  logic [15:0] plen_q, plen_d;
  logic [7:0]  skip_q, skip_d;
  logic [16:0] left_q, left_d;
  logic        unb_q, unb_d;
  logic        video_q, video_d;

  logic        byte_v;
  logic [7:0]  byte_val;
  logic        start;
  logic [7:0]  hidx_inc;
  logic [8:0]  need;
  logic        corrupt;
  out_word_t   byte_res, close_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      video_code_q <= VIDEO_CODE_RST;
      audio_code_q <= AUDIO_CODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VIDEO_CODE: video_code_q <= cfg_data_i;
        CFG_AUDIO_CODE: audio_code_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    look_d     = look_q;
    look_cnt_d = look_cnt_q;
    phase_d    = phase_q;
    hidx_d     = hidx_q;
    plen_d     = plen_q;
    skip_d     = skip_q;
    left_d     = left_q;
    unb_d      = unb_q;
    video_d    = video_q;
    byte_v     = 1'b0;
    byte_val   = 8'd0;
    start      = 1'b0;
    hidx_inc   = hidx_q + 8'd1;
    need       = 9'd0;
    corrupt    = 1'b0;

    unique case (phase_q)
      PH_SCAN: begin
        if (look_cnt_q != WINDOW_FULL) begin
          look_d     = {look_q[15:0], in_data_i.in_byte};
          look_cnt_d = look_cnt_q + 2'd1;
        end else if (look_q == START_PREFIX &&
                     (in_data_i.in_byte == video_code_q ||
                      in_data_i.in_byte == audio_code_q)) begin
          // Video wins when both registers hold the same code.
          video_d    = (in_data_i.in_byte == video_code_q);
          phase_d    = PH_HEADER;
          hidx_d     = HDR_FIRST_IDX;
          plen_d     = 16'd0;
          skip_d     = 8'd0;
          look_d     = 24'd0;
          look_cnt_d = 2'd0;
        end else begin
          byte_v   = 1'b1;
          byte_val = look_q[23:16];
          look_d   = {look_q[15:0], in_data_i.in_byte};
        end
      end
      PH_HEADER: begin
        if (hidx_q == HDR_LEN_HI_IDX || hidx_q == HDR_LEN_LO_IDX) begin
          plen_d = {plen_q[7:0], in_data_i.in_byte};
        end
        if (hidx_q >= HDR_LAST_IDX) begin
          skip_d = in_data_i.in_byte;
          hidx_d = 8'd0;
          if (in_data_i.in_byte == 8'd0) begin
            start = 1'b1;
          end else begin
            phase_d = PH_SKIP;
          end
        end else begin
          hidx_d = hidx_inc;
        end
      end
      PH_SKIP: begin
        hidx_d = hidx_inc;
        if (hidx_inc >= skip_q) begin
          hidx_d = 8'd0;
          start  = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        if (video_q) begin
          byte_v   = 1'b1;
          byte_val = in_data_i.in_byte;
        end
        if (!unb_q) begin
          left_d = left_q - 17'd1;
          if (left_d == 17'd0) begin
            phase_d    = PH_SCAN;
            look_d     = 24'd0;
            look_cnt_d = 2'd0;
          end
        end
      end
      default: ;
    endcase

    // Payload length once the header data is behind us; a length that
    // would go negative lets the payload run to the end of the buffer.
    if (start) begin
      need   = {1'b0, skip_d} + PES_FIXED_OVERHEAD;
      unb_d  = 1'b0;
      left_d = 17'd0;
      if (plen_d < {7'd0, need}) begin
        unb_d   = 1'b1;
        phase_d = PH_PAYLOAD;
      end else begin
        left_d = {1'b0, plen_d} - {8'd0, need};
        if (left_d == 17'd0) begin
          phase_d    = PH_SCAN;
          look_d     = 24'd0;
          look_cnt_d = 2'd0;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
    end

    if (in_data_i.end_of_buffer) begin
      corrupt    = (phase_d == PH_HEADER || phase_d == PH_SKIP);
      look_d     = 24'd0;
      look_cnt_d = 2'd0;
      phase_d    = PH_SCAN;
      hidx_d     = 8'd0;
      plen_d     = 16'd0;
      skip_d     = 8'd0;
      left_d     = 17'd0;
      unb_d      = 1'b0;
      video_d    = 1'b0;
    end
  end

  always_comb begin
    byte_res  = '{out_byte: byte_val, byte_valid: 1'b1, buffer_done: 1'b0, status: 1'b0};
    close_res = '{out_byte: 8'd0, byte_valid: 1'b0, buffer_done: 1'b1, status: corrupt};
    push_o.second = close_res;
    if (!accept_i) begin
      push_o.count = 2'd0;
      push_o.first = byte_res;
    end else if (byte_v && in_data_i.end_of_buffer) begin
      push_o.count = 2'd2;
      push_o.first = byte_res;
    end else if (byte_v) begin
      push_o.count = 2'd1;
      push_o.first = byte_res;
    end else if (in_data_i.end_of_buffer) begin
      push_o.count = 2'd1;
      push_o.first = close_res;
    end else begin
      push_o.count = 2'd0;
      push_o.first = byte_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      look_q     <= 24'd0;
      look_cnt_q <= 2'd0;
      phase_q    <= PH_SCAN;
      hidx_q     <= 8'd0;
      plen_q     <= 16'd0;
      skip_q     <= 8'd0;
      left_q     <= 17'd0;
      unb_q      <= 1'b0;
      video_q    <= 1'b0;
    end else if (accept_i) begin
      look_q     <= look_d;
      look_cnt_q <= look_cnt_d;
      phase_q    <= phase_d;
      hidx_q     <= hidx_d;
      plen_q     <= plen_d;
      skip_q     <= skip_d;
      left_q     <= left_d;
      unb_q      <= unb_d;
      video_q    <= video_d;
    end
  end

endmodule

>>> rtl/ppve_fifo.sv
// ----------------------------------------------------------------------------
// ppve_fifo
// Result queue: up to two results in a cycle, one out a cycle unless stalled.
// ----------------------------------------------------------------------------
module ppve_fifo import ppve_pkg::*; #(
  parameter int unsigned Depth = OUT_QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  localparam int unsigned PtrW = (Depth > 2) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] RoomMark = CntW'(Depth - 2);

  out_word_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  // Room is kept for the two results that one item can give.
  assign full_o      = (cnt_q > RoomMark);
  assign wr_ptr_nx   = ptr_inc(wr_ptr_q);

  always_comb begin
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    case (push_i.count)
      2'd1:    wr_ptr_d = wr_ptr_nx;
      2'd2:    wr_ptr_d = ptr_inc(wr_ptr_nx);
      default: wr_ptr_d = wr_ptr_q;
    endcase
    cnt_d = cnt_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> rtl/ps_pes_video_extractor.sv
// ----------------------------------------------------------------------------
// ps_pes_video_extractor
// Program-stream PES video extractor, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// Bytes of a program-stream buffer enter on the input channel, the last one
// flagged by end_of_buffer. Bytes outside PES packets and the payload of
// video PES packets leave on the output channel; audio payload, PES headers
// and up to three undecided trailing bytes are dropped. Each buffer ends
// with one closing word carrying buffer_done and the header status.
// The stream-id registers are written through the plain write port; the user
// must do so only while the block is idle, which the block does not enforce.
// A byte is parsed in the cycle it is accepted and its results are queued
// at the end of that cycle. One byte is accepted every cycle while the
// result queue has room for two words; a closing word takes its own slot.
// When the receiver stalls, results wait in the four-word queue and the
// input is stalled once fewer than two places remain.
// Reset empties the queue, returns the parser to scanning and loads the
// default stream ids; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ps_pes_video_extractor import ppve_pkg::*; #(
  parameter int unsigned OutDepth = OUT_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_word_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_data_o
);

  logic  accept;
  logic  full;
  push_t push;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  ppve_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .in_data_i  (in_data_i),
    .push_o     (push)
  );

  ppve_fifo #(
    .Depth (OutDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> test/pes_extract_checker.sv
// ----------------------------------------------------------------------------
// pes_extract_checker
// Watches both channels of the extractor, predicts and compares its words.
// ----------------------------------------------------------------------------
// Each accepted input word is run through a cycle-free model of the PES
// parser, and the words it should produce are queued. Each accepted output
// word is compared with the oldest queued word. Register writes seen on the
// write port update the model's copy of the stream ids.
// ----------------------------------------------------------------------------
module pes_extract_checker import ppve_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_word_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_word_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ReportLimit = 10;

  // Model copy of the stream ids and of the parser state.
  logic [7:0]  vid_code;
  logic [7:0]  aud_code;
  logic [23:0] win_bytes;
  logic [1:0]  win_count;
  phase_e      ph;
  logic [7:0]  hdr_idx;
  logic [15:0] pkt_len;
  logic [7:0]  skip_len;
  logic [16:0] pay_left;
  logic        pay_open;
  logic        vid_pkt;

  out_word_t expected_out [$];
  out_word_t want;
  int        failures;
  int        results_seen;

  task automatic expect_word(input logic [7:0] b, input logic v, input logic d,
                             input logic s);
    out_word_t w;
    w.out_byte    = b;
    w.byte_valid  = v;
    w.buffer_done = d;
    w.status      = s;
    expected_out.push_back(w);
  endtask

  task automatic rescan();
    ph        = PH_SCAN;
    win_bytes = '0;
    win_count = '0;
  endtask

  task automatic clear_parser();
    rescan();
    hdr_idx  = '0;
    pkt_len  = '0;
    skip_len = '0;
    pay_left = '0;
    pay_open = 1'b0;
    vid_pkt  = 1'b0;
  endtask

  // Header data done: work out how much payload follows. A length too short
  // to cover the header data leaves the payload open until the buffer ends.
  task automatic start_payload();
    logic [15:0] need;
    need     = 16'(skip_len) + 16'(PES_FIXED_OVERHEAD);
    pay_open = 1'b0;
    pay_left = '0;
    if (pkt_len < need) begin
      pay_open = 1'b1;
      ph       = PH_PAYLOAD;
    end else begin
      pay_left = 17'(pkt_len - need);
      if (pay_left == '0) rescan();
      else ph = PH_PAYLOAD;
    end
  endtask

  task automatic parse_byte(input in_word_t w);
    logic [31:0] win4;
    logic [7:0]  b;
    b = w.in_byte;
    case (ph)
      PH_SCAN: begin
        if (win_count < WINDOW_FULL) begin
          win_bytes = {win_bytes[15:0], b};
          win_count = win_count + 2'd1;
        end else begin
          win4 = {win_bytes, b};
          if (win4 == {START_PREFIX, vid_code} || win4 == {START_PREFIX, aud_code}) begin
            // With equal ids the video match is taken.
            vid_pkt   = (win4 == {START_PREFIX, vid_code});
            ph        = PH_HEADER;
            hdr_idx   = HDR_FIRST_IDX;
            pkt_len   = '0;
            skip_len  = '0;
            win_bytes = '0;
            win_count = '0;
          end else begin
            expect_word(win_bytes[23:16], 1'b1, 1'b0, 1'b0);
            win_bytes = win4[23:0];
          end
        end
      end
      PH_HEADER: begin
        if (hdr_idx == HDR_LEN_HI_IDX || hdr_idx == HDR_LEN_LO_IDX) begin
          pkt_len = {pkt_len[7:0], b};
        end
        if (hdr_idx >= HDR_LAST_IDX) begin
          skip_len = b;
          hdr_idx  = '0;
          if (b == 8'd0) start_payload();
          else ph = PH_SKIP;
        end else begin
          hdr_idx = hdr_idx + 8'd1;
        end
      end
      PH_SKIP: begin
        hdr_idx = hdr_idx + 8'd1;
        if (hdr_idx >= skip_len) begin
          hdr_idx = '0;
          start_payload();
        end
      end
      PH_PAYLOAD: begin
        if (vid_pkt) expect_word(b, 1'b1, 1'b0, 1'b0);
        if (!pay_open) begin
          pay_left = pay_left - 17'd1;
          if (pay_left == '0) rescan();
        end
      end
      default: rescan();
    endcase
    if (w.end_of_buffer) begin
      expect_word(8'h00, 1'b0, 1'b1, (ph == PH_HEADER || ph == PH_SKIP));
      clear_parser();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vid_code = VIDEO_CODE_RST;
      aud_code = AUDIO_CODE_RST;
      clear_parser();
      expected_out.delete();
      failures     = 0;
      results_seen = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_VIDEO_CODE) vid_code = cfg_data_i;
        else aud_code = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (expected_out.size() == 0) begin
          failures++;
          if (failures <= ReportLimit) begin
            $display("result %0d not expected: byte %02h valid %b last %b status %b",
                     results_seen, out_data_i.out_byte, out_data_i.byte_valid,
                     out_data_i.buffer_done, out_data_i.status);
          end
        end else begin
          want = expected_out.pop_front();
          if (out_data_i !== want) begin
            failures++;
            if (failures <= ReportLimit) begin
              $display({"result %0d mismatch: want byte %02h valid %b last %b status %b,",
                        " got byte %02h valid %b last %b status %b"},
                       results_seen, want.out_byte, want.byte_valid, want.buffer_done,
                       want.status, out_data_i.out_byte, out_data_i.byte_valid,
                       out_data_i.buffer_done, out_data_i.status);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) parse_byte(in_data_i);
      fail_count_o <= failures;
      pending_o    <= expected_out.size();
    end
  end

endmodule

>>> test/tb_ps_pes_video_extractor.sv
// ----------------------------------------------------------------------------
// tb_ps_pes_video_extractor
// Randomised buffer-level test of the program-stream video extractor.
// ----------------------------------------------------------------------------
// Feeds whole program-stream buffers: a few hand-made ones first, then
// random buffers built mostly from well-formed PES packets mixed with noise,
// broken headers and buffers cut short. The stream ids are changed between
// phases while the block is idle. Both sides idle in random bursts, the
// receiver once holds off long enough to fill the block. The checker beside
// the block does all the comparing; this module reports its count.
// ----------------------------------------------------------------------------
module tb_ps_pes_video_extractor;
  import ppve_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          PhaseCount     = 6;
  localparam int          RandomPerPhase = 275;
  localparam int          HoldAt         = 150;
  localparam int          HoldCycles     = 120;
  localparam int          QuietTail      = 150;
  localparam int          DrainCycles    = 8;
  localparam longint      TimeoutNs      = 4_000_000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_idx;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  in_word_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_word_t  out_data;
  int         fail_count;
  int         pending;

  int         sent = 0;
  int         all_goal;
  bit         quiet = 1'b0;
  bit         held_long = 1'b0;
  logic [7:0] vcode;
  logic [7:0] acode;
  logic [7:0] buf_q [$];

  always #4 clk = ~clk;

  ps_pes_video_extractor dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  pes_extract_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    #(TimeoutNs);
    $display("tb_ps_pes_video_extractor: done, errors");
    $finish;
  end

  // Bytes biased towards the start-code prefix so that windows nearly match.
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'h00;
      3:       return 8'h01;
      4:       return vcode;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_start(input logic [7:0] code);
    buf_q.push_back(8'h00);
    buf_q.push_back(8'h00);
    buf_q.push_back(8'h01);
    buf_q.push_back(code);
  endtask

  task automatic add_packet(output bit runs_to_end);
    logic [7:0]  code;
    logic [15:0] plen;
    int          hl;
    int          pay;
    int          kind;
    runs_to_end = 1'b0;
    kind = $urandom_range(0, 9);
    code = (kind < 5) ? vcode : (kind < 9) ? acode : 8'($urandom);
    if ($urandom_range(0, 39) == 0) hl = $urandom_range(0, 255);
    else if ($urandom_range(0, 4) == 0) hl = $urandom_range(0, 20);
    else hl = $urandom_range(0, 3);
    pay  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 24);
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      plen = 16'(hl + 3 + pay);
    end else if (kind < 9) begin
      // Length too short for the header data: payload runs to the end.
      plen        = 16'($urandom_range(0, hl + 2));
      pay         = $urandom_range(0, 10);
      runs_to_end = 1'b1;
    end else begin
      plen        = 16'($urandom_range(200, 65535));
      pay         = $urandom_range(1, 30);
      runs_to_end = 1'b1;
    end
    push_start(code);
    buf_q.push_back(plen[15:8]);
    buf_q.push_back(plen[7:0]);
    buf_q.push_back(8'($urandom));
    buf_q.push_back(8'($urandom));
    buf_q.push_back(8'(hl));
    repeat (hl) buf_q.push_back(8'($urandom));
    repeat (pay) buf_q.push_back(noise_byte());
  endtask

  task automatic build_buffer();
    int target;
    int seg_start;
    int cut;
    int pick;
    bit open_end;
    buf_q.delete();
    target    = $urandom_range(4, 60);
    seg_start = 0;
    open_end  = 1'b0;
    while (buf_q.size() < target && !open_end) begin
      seg_start = buf_q.size();
      pick      = $urandom_range(0, 19);
      if (pick < 12) begin
        add_packet(open_end);
      end else if (pick < 17) begin
        repeat ($urandom_range(1, 8)) buf_q.push_back(noise_byte());
      end else begin
        // A start code with a truncated header; later bytes are taken as header.
        push_start(($urandom_range(0, 1) == 1) ? vcode : acode);
        repeat ($urandom_range(0, 8)) buf_q.push_back(8'($urandom));
      end
    end
    // Often the buffer ends inside its last segment.
    if ($urandom_range(0, 2) == 0 && buf_q.size() > seg_start + 1) begin
      cut = $urandom_range(seg_start + 1, buf_q.size() - 1);
      while (buf_q.size() > cut) void'(buf_q.pop_back());
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eob);
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, end_of_buffer: eob};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    quiet = (sent >= all_goal - QuietTail);
  endtask

  task automatic send_buffer(input int idle_odds);
    for (int i = 0; i < buf_q.size(); i++) begin
      if (!quiet && idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      send_byte(buf_q[i], (i == buf_q.size() - 1));
    end
  endtask

  // Stop offering words and wait until every expected word has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_codes(input logic [7:0] v, input logic [7:0] a);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_VIDEO_CODE;
    cfg_data <= v;
    @(posedge clk);
    cfg_idx  <= CFG_AUDIO_CODE;
    cfg_data <= a;
    @(posedge clk);
    cfg_we   <= 1'b0;
    vcode = v;
    acode = a;
  endtask

  initial begin : rx_side
    int odds;
    out_stall <= 1'b0;
    odds = 3;
    @(posedge rst_n);
    forever begin
      if (!held_long && sent >= HoldAt) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end else if (!quiet && odds != 0 && $urandom_range(0, odds) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
      if ($urandom_range(0, 99) == 0) begin
        case ($urandom_range(0, 2))
          0:       odds = 0;
          1:       odds = 3;
          default: odds = 8;
        endcase
      end
    end
  end

  initial begin : tx_side
    int goal;
    rst_n    <= 1'b0;
    cfg_we   <= 1'b0;
    cfg_idx  <= CFG_VIDEO_CODE;
    cfg_data <= 8'h00;
    in_valid <= 1'b0;
    in_data  <= '0;
    vcode    = VIDEO_CODE_RST;
    acode    = AUDIO_CODE_RST;
    all_goal = 27 + PhaseCount * RandomPerPhase;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < PhaseCount; k++) begin
      case (k)
        0:       set_codes(VIDEO_CODE_RST, AUDIO_CODE_RST);
        1:       set_codes(8'hFF, 8'h00);
        2:       set_codes(8'h00, 8'hFF);
        3:       set_codes(8'hBA, 8'hBA);
        4:       set_codes(8'($urandom), 8'($urandom));
        default: set_codes(VIDEO_CODE_RST, AUDIO_CODE_RST);
      endcase
      @(posedge clk);
      if (k == 0) begin
        // Pass-through byte, dropped audio payload, empty video payload and
        // two trailing window bytes; then a header cut by the buffer end.
        buf_q = '{8'hFF, 8'h00, 8'h00, 8'h01, 8'hC0, 8'h00, 8'h04, 8'h80,
                  8'h00, 8'h00, 8'h11, 8'h00, 8'h00, 8'h01, 8'hE0, 8'h00,
                  8'h03, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00};
        send_buffer(0);
        buf_q = '{8'h00, 8'h00, 8'h01, 8'hE0, 8'hFF};
        send_buffer(0);
      end
      goal = 27 + (k + 1) * RandomPerPhase;
      while (sent < goal) begin
        build_buffer();
        send_buffer(($urandom_range(0, 2) == 0) ? 0 : 4);
        if (k == 1 && sent < goal - RandomPerPhase / 2 &&
            sent >= goal - RandomPerPhase + 40) begin
          drain();
        end
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("tb_ps_pes_video_extractor: done, clean");
    end else begin
      $display("tb_ps_pes_video_extractor: done, errors");
    end
    $finish;
  end

endmodule
